// File: sv/nar_pkg.sv
// Package for the array rotate unit: word types, register codes and control bundles.
package nar_pkg;

  localparam int NUM_AXES = 4;
  localparam int SIZE_W   = 7;
  localparam int OFF_W    = 6;
  localparam int ELEM_W   = 64;
  localparam int CFG_IW   = 3;

  localparam logic [2:0] MOD_TOP = 3'(OFF_W - 1);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_SIZE_AXIS0   = 3'd0,
    CFG_SIZE_AXIS1   = 3'd1,
    CFG_SIZE_AXIS2   = 3'd2,
    CFG_SIZE_AXIS3   = 3'd3,
    CFG_OFFSET_AXIS0 = 3'd4,
    CFG_OFFSET_AXIS1 = 3'd5,
    CFG_OFFSET_AXIS2 = 3'd6,
    CFG_OFFSET_AXIS3 = 3'd7
  } nar_cfg_e;

  typedef enum logic [2:0] {
    WK_IDLE,
    WK_MOD,
    WK_AXIS,
    WK_EMIT,
    WK_ERR
  } nar_state_e;

  typedef struct packed {
    logic              kind;
    logic [ELEM_W-1:0] element;
  } nar_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element_out;
    logic              final_res;
    logic              too_large;
  } nar_out_t;

  typedef struct packed {
    logic issue;
    logic err;
    logic last;
    logic busy;
  } nar_walk_t;

endpackage

// File: sv/nar_store.sv
// Element store: one write port, one registered read port.
module nar_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [nar_pkg::ELEM_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [nar_pkg::ELEM_W-1:0] rdata_o
);

  logic [nar_pkg::ELEM_W-1:0] mem [DEPTH];
  logic [nar_pkg::ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/nar_walk.sv
// Address walker: per-axis set-up of rotation and strides, then source address sequencing.
module nar_walk #(
  parameter int CAPACITY = 64,
  parameter int MAX_AXES = 4
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   start_i,
  input  logic                                                   adv_i,
  input  logic [nar_pkg::NUM_AXES-1:0][nar_pkg::SIZE_W-1:0]      size_i,
  input  logic [nar_pkg::NUM_AXES-1:0][nar_pkg::OFF_W-1:0]       offset_i,
  output logic [$clog2(CAPACITY)-1:0]                            addr_o,
  output nar_pkg::nar_walk_t                                     ctl_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int PW   = CW + nar_pkg::SIZE_W;
  localparam int NA   = nar_pkg::NUM_AXES;
  localparam int SW   = nar_pkg::SIZE_W;
  localparam int LEAD = nar_pkg::NUM_AXES - MAX_AXES;

  nar_pkg::nar_state_e state_q, state_d;

  logic [1:0]    axis_q;
  logic [2:0]    bit_q;
  logic [SW-1:0] rem_q;
  logic [CW-1:0] prod_q;
  logic          ovf_q;
  logic [AW-1:0] src_q;

  logic [NA-1:0][AW-1:0] stride_q;
  logic [NA-1:0][AW-1:0] wrap_q;
  logic [NA-1:0][SW-1:0] dm1_q;
  logic [NA-1:0][SW-1:0] ctr_q;
  logic [NA-1:0][SW-1:0] rot_q;

  logic [NA-1:0][SW-1:0]            d_eff;
  logic [NA-1:0][nar_pkg::OFF_W-1:0] o_eff;
  logic [SW-1:0]                    d_sel;
  logic [SW:0]                      shifted;
  logic [SW-1:0]                    rem_n;
  logic [PW-1:0]                    new_prod;
  logic [PW-1:0]                    rot_term;
  logic                             ovf_n;

  logic [NA-1:0]         step;
  logic [NA-1:0][SW-1:0] ctr_n;
  logic [NA-1:0][SW-1:0] rot_n;
  logic [AW-1:0]         src_n;
  logic                  last;
  logic                  emit_go;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (a < LEAD || size_i[a] == '0) begin
        d_eff[a] = SW'(1);
      end else begin
        d_eff[a] = size_i[a];
      end
      o_eff[a] = (a < LEAD) ? '0 : offset_i[a];
    end
  end

  assign d_sel    = d_eff[axis_q];
  assign shifted  = {rem_q, o_eff[axis_q][bit_q]};
  assign rem_n    = (shifted >= {1'b0, d_sel}) ? SW'(shifted - {1'b0, d_sel}) : SW'(shifted);
  assign new_prod = PW'(prod_q) * PW'(d_sel);
  assign rot_term = PW'(rem_q) * PW'(prod_q);
  assign ovf_n    = ovf_q || (new_prod > PW'(CAPACITY));

  always_comb begin
    step         = '0;
    step[NA-1]   = 1'b1;
    for (int a = NA - 2; a >= 0; a--) begin
      step[a] = step[a+1] && (ctr_q[a+1] == dm1_q[a+1]);
    end
    src_n = src_q;
    last  = 1'b1;
    for (int a = NA - 1; a >= 0; a--) begin
      ctr_n[a] = ctr_q[a];
      rot_n[a] = rot_q[a];
      last     = last && (ctr_q[a] == dm1_q[a]);
      if (step[a]) begin
        ctr_n[a] = (ctr_q[a] == dm1_q[a]) ? '0 : ctr_q[a] + SW'(1);
        if (rot_q[a] == dm1_q[a]) begin
          rot_n[a] = '0;
          src_n    = src_n - wrap_q[a];
        end else begin
          rot_n[a] = rot_q[a] + SW'(1);
          src_n    = src_n + stride_q[a];
        end
      end
    end
  end

  assign emit_go = (state_q == nar_pkg::WK_EMIT) && adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nar_pkg::WK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctl_o           = '0;
    ctl_o.busy      = (state_q != nar_pkg::WK_IDLE);
    case (state_q)
      nar_pkg::WK_IDLE: begin
        if (start_i) begin
          state_d = nar_pkg::WK_MOD;
        end
      end
      nar_pkg::WK_MOD: begin
        if (bit_q == '0) begin
          state_d = nar_pkg::WK_AXIS;
        end
      end
      nar_pkg::WK_AXIS: begin
        if (axis_q == '0) begin
          state_d = ovf_n ? nar_pkg::WK_ERR : nar_pkg::WK_EMIT;
        end else begin
          state_d = nar_pkg::WK_MOD;
        end
      end
      nar_pkg::WK_EMIT: begin
        ctl_o.issue = adv_i;
        ctl_o.last  = last;
        if (adv_i && last) begin
          state_d = nar_pkg::WK_IDLE;
        end
      end
      nar_pkg::WK_ERR: begin
        ctl_o.err = adv_i;
        if (adv_i) begin
          state_d = nar_pkg::WK_IDLE;
        end
      end
      default: begin
        state_d = nar_pkg::WK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= '0;
      bit_q  <= '0;
      rem_q  <= '0;
      prod_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      case (state_q)
        nar_pkg::WK_IDLE: begin
          axis_q <= 2'(NA - 1);
          bit_q  <= nar_pkg::MOD_TOP;
          rem_q  <= '0;
          prod_q <= CW'(1);
          ovf_q  <= 1'b0;
        end
        nar_pkg::WK_MOD: begin
          rem_q <= rem_n;
          bit_q <= bit_q - 3'd1;
        end
        nar_pkg::WK_AXIS: begin
          prod_q <= CW'(new_prod);
          ovf_q  <= ovf_n;
          axis_q <= axis_q - 2'd1;
          bit_q  <= nar_pkg::MOD_TOP;
          rem_q  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == nar_pkg::WK_IDLE) begin
      src_q <= '0;
    end else if (state_q == nar_pkg::WK_AXIS) begin
      src_q            <= src_q + AW'(rot_term);
      stride_q[axis_q] <= AW'(prod_q);
      wrap_q[axis_q]   <= AW'(new_prod) - AW'(prod_q);
      dm1_q[axis_q]    <= d_sel - SW'(1);
      ctr_q[axis_q]    <= '0;
      rot_q[axis_q]    <= rem_q;
    end else if (emit_go) begin
      src_q <= src_n;
      ctr_q <= ctr_n;
      rot_q <= rot_n;
    end
  end

  assign addr_o = src_q;

endmodule

// File: sv/nar_out_buf.sv
// Two-word output queue with slot reservation for reads in flight.
module nar_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rsv_i,
  input  nar_pkg::nar_out_t push_data_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nar_pkg::nar_out_t out_data_o
);

  nar_pkg::nar_out_t mem_q [2];
  logic [1:0]        cnt_q;
  logic              infl_q;
  logic              wr_q;
  logic              rd_q;
  logic              pop;
  logic [2:0]        occ;

  assign pop     = (cnt_q != '0) && !out_stall_i;
  assign occ     = 3'(cnt_q) + 3'(infl_q) - 3'(pop);
  assign space_o = (occ < 3'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      infl_q <= 1'b0;
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
    end else begin
      infl_q <= rsv_i;
      cnt_q  <= cnt_q + 2'(infl_q) - 2'(pop);
      if (infl_q) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (infl_q) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];

endmodule

// File: sv/ndim_array_rotate_unit.sv
// Load word: taken back to back while idle; loads past capacity are dropped.
// Start word: set-up per axis (6 remainder steps, 1 stride step),
// then one result word per cycle from the store read port while the output queue has space.
// Input stalls from start acceptance until the last store read, or the flagged word, is issued.
// Too-large start: one flagged word after set-up. Output queue of two words.
// Reset: sizes 1, offsets 0, load pointer 0; store contents undefined until loaded.
module ndim_array_rotate_unit #(
  parameter int CAPACITY = 64,
  parameter int MAX_AXES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  nar_pkg::nar_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output nar_pkg::nar_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [nar_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [nar_pkg::SIZE_W-1:0]    cfg_wdata_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic [nar_pkg::NUM_AXES-1:0][nar_pkg::SIZE_W-1:0] size_q;
  logic [nar_pkg::NUM_AXES-1:0][nar_pkg::OFF_W-1:0]  offset_q;
  logic [LW-1:0]                                     lp_q;

  nar_pkg::nar_walk_t          walk_ctl;
  nar_pkg::nar_out_t           push_data;
  logic [AW-1:0]               rd_addr;
  logic [nar_pkg::ELEM_W-1:0]  rd_data;
  logic                        in_acc;
  logic                        ld;
  logic                        start;
  logic                        rsv;
  logic                        space;
  logic                        last_q;
  logic                        err_q;

  assign in_stall_o = walk_ctl.busy;
  assign in_acc     = in_valid_i && !walk_ctl.busy;
  assign ld         = in_acc && (in_data_i.kind == nar_pkg::KIND_LOAD) && (lp_q < LW'(CAPACITY));
  assign start      = in_acc && (in_data_i.kind == nar_pkg::KIND_START);
  assign rsv        = walk_ctl.issue || walk_ctl.err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= {nar_pkg::NUM_AXES{nar_pkg::SIZE_W'(1)}};
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (nar_pkg::nar_cfg_e'(cfg_idx_i))
        nar_pkg::CFG_SIZE_AXIS0:   size_q[0]   <= cfg_wdata_i;
        nar_pkg::CFG_SIZE_AXIS1:   size_q[1]   <= cfg_wdata_i;
        nar_pkg::CFG_SIZE_AXIS2:   size_q[2]   <= cfg_wdata_i;
        nar_pkg::CFG_SIZE_AXIS3:   size_q[3]   <= cfg_wdata_i;
        nar_pkg::CFG_OFFSET_AXIS0: offset_q[0] <= cfg_wdata_i[nar_pkg::OFF_W-1:0];
        nar_pkg::CFG_OFFSET_AXIS1: offset_q[1] <= cfg_wdata_i[nar_pkg::OFF_W-1:0];
        nar_pkg::CFG_OFFSET_AXIS2: offset_q[2] <= cfg_wdata_i[nar_pkg::OFF_W-1:0];
        nar_pkg::CFG_OFFSET_AXIS3: offset_q[3] <= cfg_wdata_i[nar_pkg::OFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
    end else if (start) begin
      lp_q <= '0;
    end else if (ld) begin
      lp_q <= lp_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsv) begin
      last_q <= walk_ctl.last;
      err_q  <= walk_ctl.err;
    end
  end

  always_comb begin
    if (err_q) begin
      push_data.element_out = '0;
      push_data.final_res   = 1'b1;
      push_data.too_large   = 1'b1;
    end else begin
      push_data.element_out = rd_data;
      push_data.final_res   = last_q;
      push_data.too_large   = 1'b0;
    end
  end

  nar_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ld),
    .waddr_i (lp_q[AW-1:0]),
    .wdata_i (in_data_i.element),
    .re_i    (walk_ctl.issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  nar_walk #(
    .CAPACITY (CAPACITY),
    .MAX_AXES (MAX_AXES)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .adv_i    (space),
    .size_i   (size_q),
    .offset_i (offset_q),
    .addr_o   (rd_addr),
    .ctl_o    (walk_ctl)
  );

  nar_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rsv_i       (rsv),
    .push_data_i (push_data),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/nar_checker.sv
// Port checker for the array rotate unit and its bind to the top level.
module nar_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input nar_pkg::nar_in_t           in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input nar_pkg::nar_out_t          out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_err_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_large |-> out_data_o.final_res)
    else $error("too-large word not marked final");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_large |-> out_data_o.element_out == '0)
    else $error("too-large word carries data");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.kind == nar_pkg::KIND_START |=> in_stall_o)
    else $error("input not held off after start");

endmodule

bind ndim_array_rotate_unit nar_checker u_nar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: sim/ndim_array_rotate_unit_test.sv
// Self-checking testbench for ndim_array_rotate_unit: loads arrays, rotates them, checks every word.
`timescale 1ns / 100ps

module ndim_array_rotate_unit_test;

  localparam int CAPACITY       = 64;
  localparam int MAX_AXES       = 4;
  localparam int NUM_AXES       = nar_pkg::NUM_AXES;
  localparam int SIZE_W         = nar_pkg::SIZE_W;
  localparam int OFF_W          = nar_pkg::OFF_W;
  localparam int ELEM_W         = nar_pkg::ELEM_W;
  localparam int CFG_IW         = nar_pkg::CFG_IW;
  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 40;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 12;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  nar_pkg::nar_in_t    in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  nar_pkg::nar_out_t   out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_IW-1:0]   cfg_idx_i   = '0;
  logic [SIZE_W-1:0]   cfg_wdata_i = '0;

  // predictor state
  logic [ELEM_W-1:0]   elem_store [CAPACITY];
  int unsigned         load_ptr = 0;
  logic [SIZE_W-1:0]   size_reg   [NUM_AXES] = '{default: 7'd1};
  logic [OFF_W-1:0]    offset_reg [NUM_AXES] = '{default: 6'd0};

  nar_pkg::nar_in_t    send_q [$];
  nar_pkg::nar_out_t   rotated_q [$];
  nar_pkg::nar_out_t   want_word;

  int                  fault_count   = 0;
  int                  quiet_cycles  = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  phase_no      = 0;
  int                  hold_phase    = -1;
  int                  held_phase    = -1;
  int                  hold_left     = 0;
  int                  phase_tag     = 0;

  // stimulus bookkeeping: store prefix written since reset
  int                  gen_fill    = 0;
  int                  gen_written = 0;
  int                  gen_count   = 0;

  ndim_array_rotate_unit #(
    .CAPACITY (CAPACITY),
    .MAX_AXES (MAX_AXES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic int unsigned axis_dim(int a);
    if (a < NUM_AXES - MAX_AXES) return 1;
    return (size_reg[a] == '0) ? 1 : int'(size_reg[a]);
  endfunction

  function automatic int unsigned axis_offset(int a);
    if (a < NUM_AXES - MAX_AXES) return 0;
    return int'(offset_reg[a]) % axis_dim(a);
  endfunction

  function automatic int unsigned array_volume();
    int unsigned vol;
    vol = 1;
    for (int a = 0; a < NUM_AXES; a++) vol = vol * axis_dim(a);
    return vol;
  endfunction

  function automatic void rotate_word(nar_pkg::nar_in_t w);
    int unsigned dim [NUM_AXES];
    int unsigned off [NUM_AXES];
    int unsigned stride [NUM_AXES];
    int unsigned vol, rem, src, crd;
    nar_pkg::nar_out_t res;
    if (w.kind == nar_pkg::KIND_LOAD) begin
      if (load_ptr < CAPACITY) begin
        elem_store[load_ptr] = w.element;
        load_ptr++;
      end
      return;
    end
    load_ptr = 0;
    vol = array_volume();
    if (vol > CAPACITY) begin
      res.element_out = '0;
      res.final_res   = 1'b1;
      res.too_large   = 1'b1;
      rotated_q = {rotated_q, res};
      return;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      dim[a] = axis_dim(a);
      off[a] = axis_offset(a);
    end
    stride[NUM_AXES-1] = 1;
    for (int a = NUM_AXES - 2; a >= 0; a--) stride[a] = stride[a+1] * dim[a+1];
    for (int unsigned k = 0; k < vol; k++) begin
      rem = k;
      src = 0;
      for (int a = NUM_AXES - 1; a >= 0; a--) begin
        crd = rem % dim[a];
        rem = rem / dim[a];
        src = src + ((crd + off[a]) % dim[a]) * stride[a];
      end
      res.element_out = elem_store[src];
      res.final_res   = (k + 1 == vol);
      res.too_large   = 1'b0;
      rotated_q = {rotated_q, res};
    end
  endfunction

  function automatic logic [ELEM_W-1:0] random_element();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void push_load(logic [ELEM_W-1:0] e);
    nar_pkg::nar_in_t w;
    w.kind    = nar_pkg::KIND_LOAD;
    w.element = e;
    send_q = {send_q, w};
    if (gen_fill < CAPACITY) gen_fill++;
    if (gen_fill > gen_written) gen_written = gen_fill;
    gen_count++;
  endfunction

  function automatic void push_start();
    nar_pkg::nar_in_t w;
    w.kind    = nar_pkg::KIND_START;
    w.element = random_element();
    send_q = {send_q, w};
    gen_fill = 0;
    gen_count++;
  endfunction

  // full load-then-start runs for small arrays or an unfilled store; else short loads, stale starts
  function automatic void queue_sequences(int n);
    int unsigned vol;
    int          stop;
    int          r;
    vol  = array_volume();
    stop = gen_count + n;
    while (gen_count < stop) begin
      r = $urandom_range(99);
      if (vol > CAPACITY) begin
        if (r < 50) push_start();
        else push_load(random_element());
      end else if (r < 75 && (vol <= PHASE_ITEMS || vol > gen_written)) begin
        repeat (vol) push_load(random_element());
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 8)) push_load(random_element());
        push_start();
      end else if (r < 85) begin
        repeat ($urandom_range(1, 4)) push_load(random_element());
      end else if (vol <= gen_written) begin
        push_start();
      end else begin
        push_load(random_element());
      end
    end
  endfunction

  task automatic cfg_write(nar_pkg::nar_cfg_e idx, logic [SIZE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx < nar_pkg::CFG_OFFSET_AXIS0) size_reg[idx] = val;
    else offset_reg[idx - nar_pkg::CFG_OFFSET_AXIS0] = val[OFF_W-1:0];
  endtask

  // sizes and offsets packed as {axis3, axis2, axis1, axis0}
  task automatic begin_phase(logic [NUM_AXES-1:0][SIZE_W-1:0] sz,
                             logic [NUM_AXES-1:0][SIZE_W-1:0] of,
                             int send_pct, int recv_pct, bit hold);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int a = 0; a < NUM_AXES; a++)
      cfg_write(nar_pkg::nar_cfg_e'(nar_pkg::CFG_SIZE_AXIS0 + a), sz[a]);
    for (int a = 0; a < NUM_AXES; a++)
      cfg_write(nar_pkg::nar_cfg_e'(nar_pkg::CFG_OFFSET_AXIS0 + a), of[a]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    phase_tag++;
    phase_no       <= phase_tag;
    hold_phase     <= hold ? phase_tag : -1;
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (send_q.size() != 0 || in_valid_i || rotated_q.size() != 0);
  endtask

  task automatic random_settings(output logic [NUM_AXES-1:0][SIZE_W-1:0] sz,
                                 output logic [NUM_AXES-1:0][SIZE_W-1:0] of);
    int unsigned vol;
    if ($urandom_range(9) == 0) begin
      for (int a = 0; a < NUM_AXES; a++) sz[a] = SIZE_W'($urandom_range(127));
    end else begin
      do begin
        vol = 1;
        for (int a = 0; a < NUM_AXES; a++) begin
          sz[a] = SIZE_W'($urandom_range(6));
          vol   = vol * ((sz[a] == '0) ? 1 : int'(sz[a]));
        end
      end while (vol > CAPACITY);
    end
    for (int a = 0; a < NUM_AXES; a++) of[a] = SIZE_W'($urandom_range(127));
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) rotate_word(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= send_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (hold_phase == phase_no && held_phase != phase_no && out_valid_o) begin
        out_stall_i <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        held_phase  <= phase_no;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic report_field(string field, logic [ELEM_W-1:0] want, logic [ELEM_W-1:0] got);
    fault_count++;
    if (fault_count <= PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (rotated_q.size() == 0) begin
        fault_count++;
        if (fault_count <= PRINT_LIMIT)
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data_o);
      end else begin
        want_word = rotated_q.pop_front();
        if (out_data_o.element_out !== want_word.element_out)
          report_field("element_out", want_word.element_out, out_data_o.element_out);
        if (out_data_o.final_res !== want_word.final_res)
          report_field("final_res", ELEM_W'(want_word.final_res),
                       ELEM_W'(out_data_o.final_res));
        if (out_data_o.too_large !== want_word.too_large)
          report_field("too_large", ELEM_W'(want_word.too_large),
                       ELEM_W'(out_data_o.too_large));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [NUM_AXES-1:0][SIZE_W-1:0] sz;
    logic [NUM_AXES-1:0][SIZE_W-1:0] of;
    int                              mode;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single-element array, extreme element values, start with no fresh load
    begin_phase({7'd1, 7'd1, 7'd1, 7'd1}, {7'd0, 7'd0, 7'd0, 7'd0}, 0, 0, 1'b0);
    push_load('0);
    push_load('1);
    push_load(64'haaaa_aaaa_aaaa_aaaa);
    push_load(64'h5555_5555_5555_5555);
    push_start();
    push_load('1);
    push_start();
    push_start();
    wait_drained();

    // zero sizes read as one; offset bit above the register width dropped
    begin_phase({7'd4, 7'd0, 7'd1, 7'd0}, {7'h41, 7'd5, 7'd0, 7'd63}, 0, 85, 1'b0);
    repeat (4) push_load(random_element());
    push_start();
    repeat (2) push_load(random_element());
    push_start();
    wait_drained();

    // size product over capacity
    begin_phase({7'd2, 7'd2, 7'd4, 7'd5}, {7'h7f, 7'h7f, 7'h7f, 7'h7f}, 85, 0, 1'b0);
    push_start();
    push_load(random_element());
    push_start();
    wait_drained();
    begin_phase({7'd127, 7'd0, 7'd1, 7'd127}, {7'd1, 7'd2, 7'd3, 7'd4}, 0, 0, 1'b0);
    push_start();
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          sz = {7'd64, 7'd1, 7'd1, 7'd1};
          of = {7'd63, 7'd0, 7'd0, 7'd0};
        end
        1: begin
          sz = {7'd1, 7'd1, 7'd1, 7'd64};
          of = {7'd0, 7'd0, 7'd0, 7'h7f};
        end
        2: begin
          sz = {7'd2, 7'd2, 7'd4, 7'd4};
          of = {7'd63, 7'd63, 7'd63, 7'd63};
        end
        default: random_settings(sz, of);
      endcase
      mode = p % 5;
      case (mode)
        0: begin_phase(sz, of, 0, 0, 1'b0);
        1: begin_phase(sz, of, 85, 0, 1'b0);
        2: begin_phase(sz, of, 0, 85, 1'b0);
        3: begin_phase(sz, of, 36, 36, 1'b0);
        default: begin_phase(sz, of, 0, 0, 1'b1);
      endcase
      if (mode == 4) begin
        // lead with a start so the held receiver backs the block up
        if (array_volume() <= CAPACITY && array_volume() > gen_written)
          repeat (array_volume()) push_load(random_element());
        push_start();
        // hold the sender until the block has drained, then resume
        queue_sequences(PHASE_ITEMS / 2);
        wait_drained();
        queue_sequences(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        queue_sequences(PHASE_ITEMS);
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
